// ----- sv/itar_pkg.sv -----
`default_nettype none
package itar_pkg;

   localparam int WORD_BITS  = 32;
   localparam int RADIX_BITS = 5;
   localparam int CNT_BITS   = $clog2(WORD_BITS);
   localparam int PROD_BITS  = WORD_BITS + RADIX_BITS;
   localparam int TRIAL_BITS = WORD_BITS + 4;
   localparam int PC_BITS    = 3;

   localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_BITS'(10);
   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = RADIX_BITS'(2);
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = RADIX_BITS'(16);

   localparam logic [7:0] CH_ZERO        = 8'h30;
   localparam logic [7:0] CH_LETTER_BASE = 8'h57;   // 'a' - 10
   localparam logic [7:0] CH_MINUS       = 8'h2d;
   localparam logic [3:0] DEC_RADIX      = 4'd10;

   // datapath operations
   localparam logic [2:0] OP_LOAD    = 3'd0;
   localparam logic [2:0] OP_SIGN    = 3'd1;
   localparam logic [2:0] OP_MUL     = 3'd2;
   localparam logic [2:0] OP_CMP     = 3'd3;
   localparam logic [2:0] OP_DIGIT   = 3'd4;
   localparam logic [2:0] OP_DIVINIT = 3'd5;
   localparam logic [2:0] OP_DIVSTEP = 3'd6;
   localparam logic [2:0] OP_EMIT    = 3'd7;

   // jump conditions
   localparam logic [2:0] C_NEXT       = 3'd0;
   localparam logic [2:0] C_NO_REQ     = 3'd1;
   localparam logic [2:0] C_PROD_LE    = 3'd2;
   localparam logic [2:0] C_CNT_NZ     = 3'd3;
   localparam logic [2:0] C_PLACE_NZ   = 3'd4;

   localparam logic [PC_BITS-1:0] PC_LOAD    = PC_BITS'(0);
   localparam logic [PC_BITS-1:0] PC_SIGN    = PC_BITS'(1);
   localparam logic [PC_BITS-1:0] PC_MUL     = PC_BITS'(2);
   localparam logic [PC_BITS-1:0] PC_CMP     = PC_BITS'(3);
   localparam logic [PC_BITS-1:0] PC_DIGIT   = PC_BITS'(4);
   localparam logic [PC_BITS-1:0] PC_DIVINIT = PC_BITS'(5);
   localparam logic [PC_BITS-1:0] PC_DIVSTEP = PC_BITS'(6);
   localparam logic [PC_BITS-1:0] PC_EMIT    = PC_BITS'(7);

   typedef struct packed {
      logic [2:0]         op;
      logic [2:0]         cond;
      logic [PC_BITS-1:0] target;
   } uinstr_type;

   typedef struct packed {
      logic req_valid;
      logic prod_le;
      logic cnt_nz;
      logic place_nz;
      logic hold;
   } seq_status_type;

   // Microprogram. Not taken: fall through to pc + 1 (EMIT wraps to LOAD).
   function automatic uinstr_type urom(input logic [PC_BITS-1:0] pc);
      uinstr_type u;
      begin
         case (pc)
            PC_LOAD:    u = '{op: OP_LOAD,    cond: C_NO_REQ,   target: PC_LOAD};
            PC_SIGN:    u = '{op: OP_SIGN,    cond: C_NEXT,     target: PC_LOAD};
            PC_MUL:     u = '{op: OP_MUL,     cond: C_NEXT,     target: PC_LOAD};
            PC_CMP:     u = '{op: OP_CMP,     cond: C_PROD_LE,  target: PC_MUL};
            PC_DIGIT:   u = '{op: OP_DIGIT,   cond: C_CNT_NZ,   target: PC_DIGIT};
            PC_DIVINIT: u = '{op: OP_DIVINIT, cond: C_NEXT,     target: PC_LOAD};
            PC_DIVSTEP: u = '{op: OP_DIVSTEP, cond: C_CNT_NZ,   target: PC_DIVSTEP};
            PC_EMIT:    u = '{op: OP_EMIT,    cond: C_PLACE_NZ, target: PC_DIGIT};
            default:    u = '{op: OP_LOAD,    cond: C_NEXT,     target: PC_LOAD};
         endcase
         return u;
      end
   endfunction

endpackage
`default_nettype wire

// ----- sv/itar_seq.sv -----
`default_nettype none
module itar_seq
   import itar_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire seq_status_type status,
   output uinstr_type          uinstr
);

   logic [PC_BITS-1:0] pc_ff, pc_in;
   logic               taken;

   assign uinstr = urom(pc_ff);

   always_comb begin
      case (uinstr.cond)
         C_NEXT:     taken = 1'b0;
         C_NO_REQ:   taken = !status.req_valid;
         C_PROD_LE:  taken = status.prod_le;
         C_CNT_NZ:   taken = status.cnt_nz;
         C_PLACE_NZ: taken = status.place_nz;
         default:    taken = 1'b0;
      endcase
   end

   always_comb begin
      if (status.hold) begin
         pc_in = pc_ff;
      end else if (taken) begin
         pc_in = uinstr.target;
      end else begin
         pc_in = pc_ff + PC_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_LOAD;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/integer_to_ascii_radix.sv -----
`default_nettype none
// Integer to ASCII converter: each req transaction (a 32-bit word and a signed flag)
// yields a run of rsp transactions, one character each, most significant digit
// first, with rsp_last on the final one; a negative signed word gives '-' first.
// The radix is written through csr_write/csr_radix (reset 10; below 2 acts as 2,
// above 16 as 16) and must only change while no word is in flight. One word is
// converted at a time by a microcoded sequencer: it accepts the word and sends
// any sign, finds the leading place value by repeated multiplication by the
// radix, and for each digit extracts it by restoring trial subtraction, divides
// the place value by the radix with a bit-serial restoring division and sends
// the character. A full output holds the sequencer until the character is taken.
module integer_to_ascii_radix
   import itar_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [RADIX_BITS-1:0] csr_radix,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [WORD_BITS-1:0]  req_value,
   input  wire logic                  req_is_signed,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [7:0]                 rsp_ascii_char,
   output logic                       rsp_last
);

   uinstr_type     uinstr;
   seq_status_type status;

   logic [RADIX_BITS-1:0] radix_ff, radix_in;
   logic [WORD_BITS-1:0]  rem_ff, rem_in;
   logic [WORD_BITS-1:0]  place_ff, place_in;
   logic [PROD_BITS-1:0]  prod_ff, prod_in;
   logic [3:0]            digit_ff, digit_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [RADIX_BITS-1:0] divr_ff, divr_in;
   logic                  neg_ff, neg_in;
   logic                  started_ff, started_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            char_ff, char_in;
   logic                  last_ff, last_in;

   logic                  out_free;
   logic                  emit_now;
   logic                  fire;
   logic                  hold;
   logic                  prod_le;
   logic [TRIAL_BITS-1:0] trial;
   logic                  trial_fits;
   logic [RADIX_BITS:0]   div_shift;
   logic                  div_bit;
   logic [7:0]            digit_char;

   itar_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .uinstr (uinstr)
   );

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign prod_le    = (prod_ff[PROD_BITS-1:WORD_BITS] == '0)
                       && (prod_ff[WORD_BITS-1:0] <= rem_ff);
   assign trial      = TRIAL_BITS'(place_ff) << cnt_ff[1:0];
   assign trial_fits = trial <= TRIAL_BITS'(rem_ff);
   assign div_shift  = {divr_ff, place_ff[WORD_BITS-1]};
   assign div_bit    = div_shift >= {1'b0, radix_ff};
   assign digit_char = (digit_ff < DEC_RADIX) ? (CH_ZERO + 8'(digit_ff))
                                              : (CH_LETTER_BASE + 8'(digit_ff));
   // leading zeros are skipped, but the units digit always goes out
   assign emit_now   = started_ff || (digit_ff != '0) || (place_ff == '0);

   always_comb begin
      hold = 1'b0;
      fire = 1'b0;
      if (uinstr.op == OP_SIGN && neg_ff) begin
         hold = !out_free;
         fire = out_free;
      end else if (uinstr.op == OP_EMIT && emit_now) begin
         hold = !out_free;
         fire = out_free;
      end
   end

   assign status.req_valid = req_valid;
   assign status.prod_le   = prod_le;
   assign status.cnt_nz    = cnt_ff != '0;
   assign status.place_nz  = place_ff != '0;
   assign status.hold      = hold;

   always_comb begin
      radix_in = radix_ff;
      if (csr_write) begin
         if (csr_radix < RADIX_MIN) begin
            radix_in = RADIX_MIN;
         end else if (csr_radix > RADIX_MAX) begin
            radix_in = RADIX_MAX;
         end else begin
            radix_in = csr_radix;
         end
      end
   end

   always_comb begin
      rem_in     = rem_ff;
      place_in   = place_ff;
      prod_in    = prod_ff;
      digit_in   = digit_ff;
      cnt_in     = cnt_ff;
      divr_in    = divr_ff;
      neg_in     = neg_ff;
      started_in = started_ff;
      char_in    = char_ff;
      last_in    = last_ff;
      if (!hold) begin
         case (uinstr.op)
            OP_LOAD: begin
               if (req_valid) begin
                  neg_in     = req_is_signed && req_value[WORD_BITS-1];
                  rem_in     = neg_in ? (WORD_BITS'(0) - req_value) : req_value;
                  started_in = 1'b0;
               end
            end
            OP_SIGN: begin
               place_in = WORD_BITS'(1);
               // the previous run's last character may still be waiting
               if (neg_ff) begin
                  char_in = CH_MINUS;
                  last_in = 1'b0;
               end
            end
            OP_MUL: begin
               prod_in = PROD_BITS'(place_ff) * PROD_BITS'(radix_ff);
            end
            OP_CMP: begin
               if (prod_le) begin
                  place_in = prod_ff[WORD_BITS-1:0];
               end
               cnt_in   = CNT_BITS'(3);
               digit_in = '0;
            end
            OP_DIGIT: begin
               if (trial_fits) begin
                  rem_in                = rem_ff - trial[WORD_BITS-1:0];
                  digit_in[cnt_ff[1:0]] = 1'b1;
               end
               cnt_in = cnt_ff - CNT_BITS'(1);
            end
            OP_DIVINIT: begin
               cnt_in  = CNT_BITS'(WORD_BITS - 1);
               divr_in = '0;
            end
            OP_DIVSTEP: begin
               // restoring division of the place value by the radix, MSB first
               divr_in  = div_bit ? RADIX_BITS'(div_shift - {1'b0, radix_ff})
                                  : div_shift[RADIX_BITS-1:0];
               place_in = {place_ff[WORD_BITS-2:0], div_bit};
               cnt_in   = cnt_ff - CNT_BITS'(1);
            end
            OP_EMIT: begin
               if (emit_now) begin
                  char_in    = digit_char;
                  last_in    = place_ff == '0;
                  started_in = 1'b1;
               end
               cnt_in   = CNT_BITS'(3);
               digit_in = '0;
            end
            default: begin
               cnt_in = cnt_ff;
            end
         endcase
      end
   end

   always_comb begin
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff     <= RADIX_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         radix_ff     <= radix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      place_ff   <= place_in;
      prod_ff    <= prod_in;
      digit_ff   <= digit_in;
      cnt_ff     <= cnt_in;
      divr_ff    <= divr_in;
      neg_ff     <= neg_in;
      started_ff <= started_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

   assign req_ready      = uinstr.op == OP_LOAD;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_char = char_ff;
   assign rsp_last       = last_ff;

endmodule
`default_nettype wire

// ----- test/integer_to_ascii_radix_tb.sv -----
`default_nettype none
module integer_to_ascii_radix_tb;
   import itar_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 4_000_000;
   localparam int unsigned SETTLE       = 8;
   localparam int unsigned DRAIN        = 40;
   localparam int unsigned PHASE_WORDS  = 24;
   localparam int unsigned HOLD_CYCLES  = 4000;
   localparam int unsigned NUM_PHASES   = 12;
   localparam int unsigned NUM_DIRECTED = 25;

   localparam logic [RADIX_BITS-1:0] PHASE_RADIX [NUM_PHASES] =
      '{5'd2, 5'd16, 5'd10, 5'd8, 5'd0, 5'd31, 5'd3, 5'd17, 5'd1, 5'd7, 5'd5, 5'd12};
   // idle modes: none, sender gaps, receiver stalls, both
   localparam int unsigned MODE_GAP   [4] = '{0, 73, 0, 25};
   localparam int unsigned MODE_STALL [4] = '{0, 0, 73, 25};

   typedef logic [7:0] char_q_type[$];

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } char_slot_type;

   // text left empty: expected run comes from the predictor
   typedef struct {
      logic [RADIX_BITS-1:0] radix;
      logic [WORD_BITS-1:0]  value;
      bit                    as_signed;
      string                 text;
   } dir_row_type;

   dir_row_type directed_rows [NUM_DIRECTED] = '{
      '{5'd10, 32'h0000_0000, 1'b0, "0"},
      '{5'd10, 32'h0000_0000, 1'b1, "0"},
      '{5'd10, 32'hffff_ffff, 1'b0, "4294967295"},
      '{5'd10, 32'hffff_ffff, 1'b1, "-1"},
      '{5'd10, 32'h8000_0000, 1'b1, "-2147483648"},
      '{5'd10, 32'h8000_0000, 1'b0, "2147483648"},
      '{5'd10, 32'h7fff_ffff, 1'b1, "2147483647"},
      '{5'd10, 32'd9,         1'b0, "9"},
      '{5'd10, 32'd10,        1'b0, "10"},
      '{5'd10, 32'd999999999, 1'b0, ""},
      '{5'd2,  32'h0000_0000, 1'b0, "0"},
      '{5'd2,  32'hffff_ffff, 1'b0, ""},
      '{5'd2,  32'h8000_0000, 1'b1, ""},
      '{5'd2,  32'd5,         1'b0, "101"},
      '{5'd16, 32'hdead_beef, 1'b0, "deadbeef"},
      '{5'd16, 32'hffff_ffff, 1'b1, "-1"},
      '{5'd16, 32'h8000_0000, 1'b1, "-80000000"},
      '{5'd16, 32'h0abc_def0, 1'b0, "abcdef0"},
      '{5'd0,  32'd6,         1'b0, "110"},
      '{5'd1,  32'h8000_0001, 1'b1, ""},
      '{5'd31, 32'd255,       1'b0, "ff"},
      '{5'd17, 32'hffff_fff0, 1'b1, "-10"},
      '{5'd3,  32'hffff_ffff, 1'b0, ""},
      '{5'd7,  32'h1234_5678, 1'b1, ""},
      '{5'd10, 32'd1000000000, 1'b0, "1000000000"}
   };

   logic                  clock;
   logic                  reset         = 1'b1;
   logic                  csr_write     = 1'b0;
   logic [RADIX_BITS-1:0] csr_radix     = '0;
   logic                  req_valid     = 1'b0;
   logic                  req_ready;
   logic [WORD_BITS-1:0]  req_value     = '0;
   logic                  req_is_signed = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready     = 1'b0;
   logic [7:0]            rsp_ascii_char;
   logic                  rsp_last;

   char_slot_type         pending_chars[$];
   logic [RADIX_BITS-1:0] radix_now     = RADIX_RESET;
   int unsigned           mismatches    = 0;
   int unsigned           send_gap_pct  = 0;
   int unsigned           rsp_stall_pct = 0;
   int unsigned           hold_request  = 0;
   int unsigned           hold_left     = 0;

   integer_to_ascii_radix i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_radix      (csr_radix),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .req_is_signed  (req_is_signed),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int unsigned digit_base(logic [RADIX_BITS-1:0] radix);
      if (radix < RADIX_MIN) return RADIX_MIN;
      if (radix > RADIX_MAX) return RADIX_MAX;
      return radix;
   endfunction

   // characters of one conversion, most significant first
   function automatic char_q_type ascii_digits(logic [WORD_BITS-1:0] word, bit as_signed,
                                               logic [RADIX_BITS-1:0] radix);
      char_q_type           txt;
      logic [WORD_BITS-1:0] mag;
      logic [WORD_BITS-1:0] base;
      logic [7:0]           d;
      bit                   neg;
      base = WORD_BITS'(digit_base(radix));
      neg  = as_signed && word[WORD_BITS-1];
      mag  = neg ? -word : word;
      do begin
         d = 8'(mag % base);
         txt.push_front(d < 8'd10 ? CH_ZERO + d : CH_LETTER_BASE + d);
         mag = mag / base;
      end while (mag != 0);
      if (neg) txt.push_front(CH_MINUS);
      return txt;
   endfunction

   function automatic logic [WORD_BITS-1:0] pick_word(int unsigned base, bit as_signed);
      logic [WORD_BITS-1:0] w;
      longint unsigned      p;
      int unsigned          k;
      case ($urandom_range(9))
         0, 1, 2, 3: w = $urandom;
         4, 5, 6:    w = $urandom >> $urandom_range(31);
         7: begin
            case ($urandom_range(4))
               0:       w = 32'h0000_0000;
               1:       w = 32'h8000_0000;
               2:       w = 32'hffff_ffff;
               3:       w = 32'h7fff_ffff;
               default: w = 32'h0000_0001;
            endcase
         end
         default: begin
            // around a power of the radix: leading place boundary
            p = 1;
            k = $urandom_range(1, 32);
            repeat (k) if (p * base <= 64'hffff_ffff) p = p * base;
            w = WORD_BITS'(p + $urandom_range(2) - 1);
            if (as_signed && $urandom_range(1)) w = -w;
         end
      endcase
      return w;
   endfunction

   // block is idle only once every character has arrived
   task automatic set_radix(logic [RADIX_BITS-1:0] radix);
      req_valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_write <= 1'b1;
      csr_radix <= radix;
      @(posedge clock);
      csr_write <= 1'b0;
      radix_now = radix;
   endtask

   task automatic offer_word(logic [WORD_BITS-1:0] word, bit as_signed, char_q_type txt);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_valid     <= 1'b1;
      req_value     <= word;
      req_is_signed <= as_signed;
      do @(posedge clock); while (!req_ready);
      foreach (txt[i]) pending_chars.push_back('{ch: txt[i], last: (i == txt.size() - 1)});
   endtask

   // receiver: random stalls, plus long hold-offs to back up the input
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left  = hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : rsp_check
      char_slot_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_chars.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transaction: char %h last %b", rsp_ascii_char, rsp_last);
         end else begin
            want = pending_chars.pop_front();
            if (rsp_ascii_char !== want.ch || rsp_last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected char %h last %b, got char %h last %b",
                           want.ch, want.last, rsp_ascii_char, rsp_last);
            end
         end
      end
   end

   initial begin : watchdog
      for (int unsigned n = 0; n < CYCLE_LIMIT; n++) @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      char_q_type           txt;
      logic [WORD_BITS-1:0] word;
      bit                   as_signed;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         if (directed_rows[r].radix != radix_now) set_radix(directed_rows[r].radix);
         if (directed_rows[r].text.len() == 0) begin
            txt = ascii_digits(directed_rows[r].value, directed_rows[r].as_signed, radix_now);
         end else begin
            txt = {};
            for (int i = 0; i < directed_rows[r].text.len(); i++)
               txt.push_back(directed_rows[r].text[i]);
         end
         offer_word(directed_rows[r].value, directed_rows[r].as_signed, txt);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         set_radix(PHASE_RADIX[p]);
         send_gap_pct  = MODE_GAP[p % 4];
         rsp_stall_pct = MODE_STALL[p % 4];
         if (p == 0 || p == 6) hold_request = HOLD_CYCLES;
         repeat (PHASE_WORDS) begin
            as_signed = $urandom_range(1);
            word      = pick_word(digit_base(radix_now), as_signed);
            offer_word(word, as_signed, ascii_digits(word, as_signed, radix_now));
         end
      end

      req_valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
`default_nettype wire
